>>> sv/bfc_pkg.sv
// Shared constants, codes and types of the button feedback controller.
`timescale 1ns / 1ps

package bfc_pkg;

    // Default parameter values
    localparam int BFC_BUTTON_COUNT      = 4;
    localparam int BFC_TOGGLE_LOCKOUT_MS = 1000;

    // Fixed widths
    localparam int BTN_MAX   = 4;
    localparam int TIMER_W   = 13;
    localparam int HOLD_W    = 8;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;
    localparam int BTN_IDX_W = 2;

    // One hold unit is 20 ticks of 1 ms
    localparam logic [TIMER_W-1:0] HOLD_UNIT_MS = TIMER_W'(20);

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_SET   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EMERGENCY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_FIRST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_SECOND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_THIRD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_FOURTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEND_ENABLE = 3'd5;

    // Per-button control from the top level
    typedef struct packed {
        logic step;      // word advances this cycle
        logic tick;      // operation is a tick
        logic set;       // set-emergency command
        logic clr;       // clear-emergency command
        logic press;     // press edge of this button
        logic is_emerg;  // this button is the emergency button
    } lane_ctl_t;

    // Per-button result of one word
    typedef struct packed {
        logic fb;        // feedback bit after this word
        logic req;       // bit change requests a message
        logic emerg;     // emergency press seen
    } lane_res_t;

endpackage

>>> sv/bfc_if.sv
// Channel interfaces: input words, result words and register writes.
`timescale 1ns / 1ps

interface bfc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [3:0] pressed_mask;

    modport source (output valid, output operation, output pressed_mask, input ready);
    modport sink   (input valid, input operation, input pressed_mask, output ready);
endinterface

interface bfc_out_if;
    logic       valid;
    logic       ready;
    logic       send_valid;
    logic [3:0] feedback_nibble;
    logic       emergency_pressed;

    modport source (output valid, output send_valid, output feedback_nibble,
                    output emergency_pressed, input ready);
    modport sink   (input valid, input send_valid, input feedback_nibble,
                    input emergency_pressed, output ready);
endinterface

interface bfc_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/bfc_lane.sv
// One button: hold / lockout timer and next feedback bit.
`timescale 1ns / 1ps

module bfc_lane
    import bfc_pkg::*;
#(
    parameter int LOCKOUT_MS = BFC_TOGGLE_LOCKOUT_MS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  lane_ctl_t         ctl,
    input  logic [HOLD_W-1:0] hold_time,
    input  logic              fb_cur,
    output lane_res_t         res
);

    localparam logic [TIMER_W-1:0] LOCKOUT = TIMER_W'(LOCKOUT_MS);

    logic [TIMER_W-1:0] timer_reg;
    logic [TIMER_W-1:0] timer_next;
    logic [TIMER_W-1:0] hold_ticks;
    logic               is_push;
    logic               loaded;

    assign is_push    = (hold_time != '0);
    // hold * 20 stays below 2^13
    assign hold_ticks = TIMER_W'({{(TIMER_W-HOLD_W){1'b0}}, hold_time} * HOLD_UNIT_MS);

    // Presses, then countdown of a timer not reloaded; set or clear
    always_comb
    begin
        timer_next = timer_reg;
        res        = '{fb: fb_cur, req: 1'b0, emerg: 1'b0};
        loaded     = 1'b0;
        if (ctl.tick)
        begin
            if (ctl.press)
            begin
                if (ctl.is_emerg)
                begin
                    res.emerg = 1'b1;
                end
                else if (is_push)
                begin
                    if (timer_reg == '0)
                    begin
                        res.fb  = 1'b1;
                        res.req = 1'b1;
                    end
                    timer_next = hold_ticks;
                    loaded     = 1'b1;
                end
                else if (timer_reg == '0)
                begin
                    res.fb     = ~fb_cur;
                    res.req    = 1'b1;
                    timer_next = LOCKOUT;
                    loaded     = 1'b1;
                end
            end
            if (!loaded && timer_reg != '0)
            begin
                timer_next = timer_reg - TIMER_W'(1);
                if (timer_next == '0 && is_push)
                begin
                    res.fb  = 1'b0;
                    res.req = 1'b1;
                end
            end
        end
        else if (ctl.set && ctl.is_emerg)
        begin
            res.fb     = 1'b1;
            res.req    = 1'b1;
            timer_next = hold_ticks;
        end
        else if (ctl.clr && ctl.is_emerg)
        begin
            res.fb  = 1'b0;
            res.req = 1'b1;
        end
    end

    // Timer register, zero means stopped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= '0;
        end
        else if (ctl.step)
        begin
            timer_reg <= timer_next;
        end
    end

endmodule

>>> sv/button_feedback_controller_top.sv
// Top level of the button feedback controller.
// Path: an accepted input word passes the input register, then the result register.
// Throughput: one word per cycle without result stalls; input and result registers
//   both advance together, so the stall of the result side reaches the input side.
// Reset: rst_n clears feedback bits, timers, pending request and both stages;
//   emergency button 0, hold times 0, sending enabled.
`timescale 1ns / 1ps

module button_feedback_controller_top
    import bfc_pkg::*;
#(
    parameter int BUTTON_COUNT      = BFC_BUTTON_COUNT,
    parameter int TOGGLE_LOCKOUT_MS = BFC_TOGGLE_LOCKOUT_MS
)
(
    input  logic       clk,
    input  logic       rst_n,
    bfc_cfg_if.sink    cfg,
    bfc_in_if.sink     req,
    bfc_out_if.source  rsp
);

    // Configuration registers
    logic [BTN_IDX_W-1:0] emerg_btn_reg;
    logic [HOLD_W-1:0]    hold_reg [BTN_MAX];
    logic                 send_en_reg;

    // Input stage
    logic                 in_valid_reg;
    logic [OP_W-1:0]      op_reg;
    logic [BTN_MAX-1:0]   mask_reg;

    // Result stage
    logic                 out_valid_reg;
    logic                 sent_reg;
    logic [BTN_MAX-1:0]   nibble_reg;
    logic                 emerg_reg;

    // Block state
    logic [BTN_MAX-1:0]   fb_reg;
    logic [BTN_MAX-1:0]   fb_next;
    logic                 pending_reg;
    logic                 pending_next;
    logic                 sent_next;
    logic                 any_req;
    logic                 any_emerg;
    logic [BTN_MAX-1:0]   lane_req;
    logic [BTN_MAX-1:0]   lane_emerg;
    logic                 advance;
    logic                 is_tick;

    assign cfg.ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign is_tick   = (op_reg == OP_TICK);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emerg_btn_reg <= '0;
            for (int i = 0; i < BTN_MAX; i++)
            begin
                hold_reg[i] <= '0;
            end
            send_en_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_EMERGENCY:   emerg_btn_reg <= cfg.data[BTN_IDX_W-1:0];
                REG_HOLD_FIRST:  hold_reg[0]   <= cfg.data;
                REG_HOLD_SECOND: hold_reg[1]   <= cfg.data;
                REG_HOLD_THIRD:  hold_reg[2]   <= cfg.data;
                REG_HOLD_FOURTH: hold_reg[3]   <= cfg.data;
                REG_SEND_ENABLE: send_en_reg   <= cfg.data[0];
                default:         ;
            endcase
        end
    end

    // Button lanes; buttons beyond the count keep their bit and do nothing
    for (genvar g = 0; g < BTN_MAX; g++)
    begin : g_lane
        if (g < BUTTON_COUNT)
        begin : g_on
            lane_ctl_t ctl;
            lane_res_t res;

            assign ctl = '{step:     advance,
                           tick:     is_tick,
                           set:      (op_reg == OP_SET),
                           clr:      (op_reg == OP_CLEAR),
                           press:    mask_reg[g],
                           is_emerg: (emerg_btn_reg == BTN_IDX_W'(g))};

            bfc_lane #(
                .LOCKOUT_MS (TOGGLE_LOCKOUT_MS)
            ) u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .hold_time (hold_reg[g]),
                .fb_cur    (fb_reg[g]),
                .res       (res)
            );

            assign fb_next[g]    = res.fb;
            assign lane_req[g]   = res.req;
            assign lane_emerg[g] = res.emerg;
        end
        else
        begin : g_off
            assign fb_next[g]    = fb_reg[g];
            assign lane_req[g]   = 1'b0;
            assign lane_emerg[g] = 1'b0;
        end
    end

    // Message request and send decision
    assign any_req   = |lane_req;
    assign any_emerg = |lane_emerg;

    always_comb
    begin
        sent_next    = 1'b0;
        pending_next = pending_reg | any_req;
        if (is_tick && pending_next && send_en_reg)
        begin
            sent_next    = 1'b1;
            pending_next = 1'b0;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fb_reg        <= '0;
            pending_reg   <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                fb_reg        <= fb_next;
                pending_reg   <= pending_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg   <= req.operation;
            mask_reg <= req.pressed_mask;
        end
        if (advance)
        begin
            sent_reg   <= sent_next;
            nibble_reg <= fb_next;
            emerg_reg  <= is_tick && any_emerg;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.send_valid        = sent_reg;
    assign rsp.feedback_nibble   = nibble_reg;
    assign rsp.emergency_pressed = emerg_reg;

endmodule

>>> sv/bfc_checker.sv
// Port-level checks of the button feedback controller, bound to the top level.
`timescale 1ns / 1ps

module bfc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_send,
    input logic [3:0] out_nibble,
    input logic       out_emerg
);

    // A stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_send)
            && $stable(out_nibble) && $stable(out_emerg))
        else $error("stalled result word changed");

    // With the result side empty the input side takes words
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready while result stage empty");

    // An accepted word is followed by a valid result word
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 out_valid)
        else $error("accepted word produced no result");

    // A fresh result comes from an earlier accepted word
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result word without an accepted input word");

endmodule

bind button_feedback_controller_top bfc_checker u_bfc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_send   (rsp.send_valid),
    .out_nibble (rsp.feedback_nibble),
    .out_emerg  (rsp.emergency_pressed)
);

>>> dv/tb_button_feedback_controller_top.sv
// Self-checking testbench for the button feedback controller: directed table, then random words.
`timescale 1ns / 1ps

module tb_button_feedback_controller_top;
    import bfc_pkg::*;

    localparam int  CLK_HALF_NS   = 4;
    localparam int  RESET_CYCLES  = 9;
    localparam int  PHASE_WORDS   = 220;
    localparam int  PHASES        = 4;
    localparam int  HOLD_OFF_CYC  = 200;
    localparam int  DRAIN_CYCLES  = 8;
    localparam int  MAX_PRINTS    = 40;
    localparam real LIMIT_NS      = 8.0 * 400000.0;

    // Operation code the block must ignore
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [TIMER_W-1:0] LOCKOUT_TICKS = TIMER_W'(BFC_TOGGLE_LOCKOUT_MS);

    typedef struct packed {
        logic       send;
        logic [3:0] nibble;
        logic       emerg;
    } feedback_word_t;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_DAT_W-1:0] reg_val;
        logic [OP_W-1:0]      op;
        logic [3:0]           mask;
        logic                 typed;
        feedback_word_t       want;
    } dir_row_t;

    localparam int DIR_ROWS = 25;

    // Directed table; typed rows carry the result read straight off the spec
    dir_row_t dir_table [DIR_ROWS] = '{
        // after reset: nothing happens
        '{1'b0, REG_EMERGENCY, 8'd0, OP_TICK, 4'b0000, 1'b1, '{1'b0, 4'b0000, 1'b0}},
        // emergency button only reports its press
        '{1'b0, REG_EMERGENCY, 8'd0, OP_TICK, 4'b0001, 1'b1, '{1'b0, 4'b0000, 1'b1}},
        // toggle press flips the bit and sends
        '{1'b0, REG_EMERGENCY, 8'd0, OP_TICK, 4'b0010, 1'b1, '{1'b1, 4'b0010, 1'b0}},
        // toggle press during lockout is ignored
        '{1'b0, REG_EMERGENCY, 8'd0, OP_TICK, 4'b0010, 1'b1, '{1'b0, 4'b0010, 1'b0}},
        // all buttons at once
        '{1'b0, REG_EMERGENCY, 8'd0, OP_TICK, 4'b1111, 1'b1, '{1'b1, 4'b1110, 1'b1}},
        // set and clear of the emergency bit, nothing sent
        '{1'b0, REG_EMERGENCY, 8'd0, OP_SET, 4'b1111, 1'b1, '{1'b0, 4'b1111, 1'b0}},
        '{1'b0, REG_EMERGENCY, 8'd0, OP_CLEAR, 4'b0000, 1'b1, '{1'b0, 4'b1110, 1'b0}},
        // next tick sends the pending message
        '{1'b0, REG_EMERGENCY, 8'd0, OP_TICK, 4'b0000, 1'b1, '{1'b1, 4'b1110, 1'b0}},
        // unused code changes nothing
        '{1'b0, REG_EMERGENCY, 8'd0, OP_UNUSED, 4'b1111, 1'b1, '{1'b0, 4'b1110, 1'b0}},
        // sending disabled keeps the request pending
        '{1'b1, REG_SEND_ENABLE, 8'd0, OP_TICK, 4'b0000, 1'b0, '0},
        '{1'b0, REG_EMERGENCY, 8'd0, OP_CLEAR, 4'b0000, 1'b1, '{1'b0, 4'b1110, 1'b0}},
        '{1'b0, REG_EMERGENCY, 8'd0, OP_TICK, 4'b0000, 1'b1, '{1'b0, 4'b1110, 1'b0}},
        '{1'b1, REG_SEND_ENABLE, 8'd1, OP_TICK, 4'b0000, 1'b0, '0},
        '{1'b0, REG_EMERGENCY, 8'd0, OP_TICK, 4'b0000, 1'b1, '{1'b1, 4'b1110, 1'b0}},
        // push buttons, longest hold, emergency moved to the top button
        '{1'b1, REG_HOLD_FIRST, 8'd255, OP_TICK, 4'b0000, 1'b0, '0},
        '{1'b1, REG_HOLD_SECOND, 8'd1, OP_TICK, 4'b0000, 1'b0, '0},
        '{1'b1, REG_EMERGENCY, 8'd3, OP_TICK, 4'b0000, 1'b0, '0},
        '{1'b0, REG_EMERGENCY, 8'd0, OP_TICK, 4'b0001, 1'b0, '0},
        // push retrigger while running
        '{1'b0, REG_EMERGENCY, 8'd0, OP_TICK, 4'b0001, 1'b0, '0},
        '{1'b0, REG_EMERGENCY, 8'd0, OP_TICK, 4'b1000, 1'b0, '0},
        // emergency push button: set loads its hold timer
        '{1'b1, REG_HOLD_FOURTH, 8'd2, OP_TICK, 4'b0000, 1'b0, '0},
        '{1'b0, REG_EMERGENCY, 8'd0, OP_SET, 4'b0000, 1'b0, '0},
        // push press on a button whose lockout timer still runs
        '{1'b0, REG_EMERGENCY, 8'd0, OP_TICK, 4'b0010, 1'b0, '0},
        '{1'b0, REG_EMERGENCY, 8'd0, OP_CLEAR, 4'b1111, 1'b0, '0},
        '{1'b0, REG_EMERGENCY, 8'd0, OP_TICK, 4'b1111, 1'b0, '0}
    };

    // Register write order for a full configuration
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [6] = '{
        REG_EMERGENCY, REG_HOLD_FIRST, REG_HOLD_SECOND,
        REG_HOLD_THIRD, REG_HOLD_FOURTH, REG_SEND_ENABLE
    };

    // Fixed phase settings; the last phase is drawn at random
    logic [CFG_DAT_W-1:0] phase_cfg [3][6] = '{
        '{8'd1, 8'd1,   8'd0, 8'd2, 8'd0,   8'd1},
        '{8'd3, 8'd255, 8'd1, 8'd0, 8'd3,   8'd0},
        '{8'd2, 8'd0,   8'd3, 8'd1, 8'd0,   8'd1}
    };

    logic clk;
    logic rst_n;

    bfc_cfg_if cfg_ch ();
    bfc_in_if  req_ch ();
    bfc_out_if rsp_ch ();

    button_feedback_controller_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow configuration
    logic [BTN_IDX_W-1:0] sh_emerg;
    logic [HOLD_W-1:0]    sh_hold [BTN_MAX];
    logic                 sh_send_en;

    // Shadow button state
    logic [3:0]           sh_fb;
    logic [TIMER_W-1:0]   sh_timer [BTN_MAX];
    logic                 sh_pending;

    feedback_word_t expected_feedback [$];
    int                   mismatch_count;

    int                   src_idle_pct;
    int                   sink_idle_pct;
    int                   cur_phase;
    logic                 sending;
    int                   hold_left;
    logic                 hold_done;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        // keep the log short when the block is badly off
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t: mismatch: %s", $realtime, msg);
    endtask

    function automatic logic [TIMER_W-1:0] hold_ticks(input int btn);
        return TIMER_W'(sh_hold[btn]) * HOLD_UNIT_MS;
    endfunction

    // Advance the shadow state by one input word and return its result word
    task automatic advance_buttons(input logic [OP_W-1:0] op, input logic [3:0] mask,
                                   output feedback_word_t res);
        logic is_push;
        logic loaded;
        res = '0;
        if (op == OP_TICK)
        begin
            for (int b = 0; b < BFC_BUTTON_COUNT; b++)
            begin
                is_push = (sh_hold[b] != '0);
                loaded  = 1'b0;
                if (mask[b])
                begin
                    if (b == int'(sh_emerg))
                        res.emerg = 1'b1;
                    else if (is_push)
                    begin
                        if (sh_timer[b] == '0)
                        begin
                            sh_fb[b]   = 1'b1;
                            sh_pending = 1'b1;
                        end
                        sh_timer[b] = hold_ticks(b);
                        loaded      = 1'b1;
                    end
                    else if (sh_timer[b] == '0)
                    begin
                        sh_fb[b]    = ~sh_fb[b];
                        sh_timer[b] = LOCKOUT_TICKS;
                        sh_pending  = 1'b1;
                        loaded      = 1'b1;
                    end
                end
                // free-running countdown; push bits drop on expiry
                if (!loaded && sh_timer[b] != '0)
                begin
                    sh_timer[b] = sh_timer[b] - 1'b1;
                    if (sh_timer[b] == '0 && is_push)
                    begin
                        sh_fb[b]   = 1'b0;
                        sh_pending = 1'b1;
                    end
                end
            end
            if (sh_pending && sh_send_en)
            begin
                res.send   = 1'b1;
                sh_pending = 1'b0;
            end
        end
        else if (op == OP_SET)
        begin
            sh_fb[sh_emerg]    = 1'b1;
            sh_pending         = 1'b1;
            sh_timer[sh_emerg] = hold_ticks(int'(sh_emerg));
        end
        else if (op == OP_CLEAR)
        begin
            sh_fb[sh_emerg] = 1'b0;
            sh_pending      = 1'b1;
        end
        res.nibble = sh_fb;
    endtask

    // Offer one input word; returns at the edge where it is taken
    task automatic send_word(input logic [OP_W-1:0] op, input logic [3:0] mask,
                             input logic typed, input feedback_word_t want);
        feedback_word_t pred;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.pressed_mask <= mask;
        do
            @(posedge clk);
        while (!req_ch.ready);
        advance_buttons(op, mask, pred);
        expected_feedback.push_back(typed ? want : pred);
    endtask

    // Register write; leaves the channel idle after it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_EMERGENCY:   sh_emerg   = val[BTN_IDX_W-1:0];
            REG_HOLD_FIRST:  sh_hold[0] = val;
            REG_HOLD_SECOND: sh_hold[1] = val;
            REG_HOLD_THIRD:  sh_hold[2] = val;
            REG_HOLD_FOURTH: sh_hold[3] = val;
            REG_SEND_ENABLE: sh_send_en = val[0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering and wait until every expected word has come back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_feedback.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:       begin src_idle_pct = 35; sink_idle_pct = 60; end
            1:       begin src_idle_pct = 60; sink_idle_pct = 35; end
            default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
        endcase
    endtask

    // Result side: check accepted words, drive ready with random stalls and one long hold-off
    always @(posedge clk)
    begin
        feedback_word_t want;
        if (!rst_n)
        begin
            hold_left    <= 0;
            hold_done    <= 1'b0;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_feedback.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                begin
                    want = expected_feedback.pop_front();
                    if (rsp_ch.send_valid !== want.send)
                        report_mismatch($sformatf("send_valid got %0b expected %0b",
                                                  rsp_ch.send_valid, want.send));
                    if (rsp_ch.feedback_nibble !== want.nibble)
                        report_mismatch($sformatf("feedback_nibble got %b expected %b",
                                                  rsp_ch.feedback_nibble, want.nibble));
                    if (rsp_ch.emergency_pressed !== want.emerg)
                        report_mismatch($sformatf("emergency_pressed got %0b expected %0b",
                                                  rsp_ch.emergency_pressed, want.emerg));
                end
            end
            // one long hold-off while the sender keeps offering
            if (hold_left > 0)
            begin
                hold_left    <= hold_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (cur_phase == 3 && sending && !hold_done)
            begin
                hold_left    <= HOLD_OFF_CYC;
                hold_done    <= 1'b1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Stimulus
    initial
    begin
        logic [OP_W-1:0]      op;
        logic [3:0]           mask;
        logic [CFG_DAT_W-1:0] val;
        int                   pick;

        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.operation    <= OP_TICK;
        req_ch.pressed_mask <= 4'b0000;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= REG_EMERGENCY;
        cfg_ch.data         <= '0;

        // reset values of the shadow copy
        sh_emerg       = '0;
        sh_send_en     = 1'b1;
        sh_fb          = '0;
        sh_pending     = 1'b0;
        for (int b = 0; b < BTN_MAX; b++)
        begin
            sh_hold[b]  = '0;
            sh_timer[b] = '0;
        end
        mismatch_count = 0;
        cur_phase      = 0;
        sending        = 1'b0;
        set_idling(0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_table[r].is_cfg)
            begin
                wait_drained();
                write_reg(dir_table[r].reg_idx, dir_table[r].reg_val);
            end
            else
                send_word(dir_table[r].op, dir_table[r].mask,
                          dir_table[r].typed, dir_table[r].want);
        end
        wait_drained();

        // random phases, one setting each
        for (int p = 0; p < PHASES; p++)
        begin
            for (int k = 0; k < 6; k++)
            begin
                if (p < 3)
                    val = phase_cfg[p][k];
                else if (REG_ORDER[k] == REG_EMERGENCY)
                    val = CFG_DAT_W'($urandom_range(3));
                else if (REG_ORDER[k] == REG_SEND_ENABLE)
                    val = CFG_DAT_W'($urandom_range(3) != 0);
                else
                begin
                    pick = $urandom_range(9);
                    val  = (pick < 3) ? 8'd0 : (pick < 9) ? CFG_DAT_W'($urandom_range(1, 4))
                                                          : 8'd255;
                end
                write_reg(REG_ORDER[k], val);
            end
            set_idling((p < 2) ? p : 2);
            cur_phase = p + 1;
            sending   = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                pick = $urandom_range(99);
                op   = (pick < 88) ? OP_TICK : (pick < 94) ? OP_SET :
                       (pick < 98) ? OP_CLEAR : OP_UNUSED;
                // mostly sparse presses so timers get to run out
                pick = $urandom_range(9);
                if (pick < 2)
                    mask = 4'b0000;
                else if (pick < 9)
                begin
                    for (int b = 0; b < 4; b++)
                        mask[b] = ($urandom_range(9) == 0);
                end
                else
                    mask = 4'($urandom_range(15));
                send_word(op, mask, 1'b0, '0);
            end
            sending = 1'b0;
            wait_drained();
        end

        // let any stray word show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_feedback.size() != 0)
            report_mismatch("expected words left over");
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
